// ===== design/cps_pkg.sv =====
// Shared constants for the closest-point-on-segment pipeline.
package cps_pkg;
  // Number of fraction bits in every coordinate code.
  localparam int unsigned FracBits = 4;
endpackage

// ===== design/cps_sqrt_stage.sv =====
// One registered step of the restoring integer square root.
module cps_sqrt_stage
  import cps_pkg::*;
#(
  parameter int unsigned VW = 64,
  parameter int unsigned RW = 33,
  parameter int unsigned BitIdx = 0,
  parameter int unsigned FW = 16,
  parameter int unsigned SW = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [VW-1:0]        rem_i,
  input  logic [RW-1:0]        root_i,
  input  logic signed [FW-1:0] fx_i,
  input  logic signed [FW-1:0] fy_i,
  output logic                 valid_o,
  output logic [VW-1:0]        rem_o,
  output logic [RW-1:0]        root_o,
  output logic signed [FW-1:0] fx_o,
  output logic signed [FW-1:0] fy_o
);
  // Trial subtraction of (4*root + 1) << 2*BitIdx against the remainder.
  // The root so far holds the bits above BitIdx, so setting this bit grows
  // the square by 2*root*2^(2*BitIdx+1) + 2^(2*BitIdx).
  logic [VW+1:0] trial;
  logic [VW+1:0] rem_ext;
  logic          fits;
  logic          valid_q;
  logic [VW-1:0] rem_q;
  logic [RW-1:0] root_q;
  logic signed [FW-1:0] fx_q, fy_q;

  assign trial   = (({{(VW+2-RW){1'b0}}, root_i} << 2) | (VW+2)'(1)) << (2 * BitIdx);
  assign rem_ext = {2'b00, rem_i};
  assign fits    = rem_ext >= trial;

  // Valid bit of this step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload of this step.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= fits ? VW'(rem_ext - trial) : rem_i;
      root_q <= {root_i[RW-2:0], fits};
      fx_q   <= fx_i;
      fy_q   <= fy_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign fx_o    = fx_q;
  assign fy_o    = fy_q;
  logic unused;
  assign unused = ^SW;
endmodule

// ===== design/closest_point_on_segment.sv =====
// Top level: clamped projection of a point onto a segment and the distance to it.
// Fully pipelined: one request is accepted every cycle while the output is taken.
// Stages in order: differences, products, the case decision, a pipelined
// restoring divider for t (a load stage, then one quotient bit per stage), two
// interpolation stages, squared distance, and a square root that resolves one
// root bit per stage. A stall at the output freezes the whole pipeline; ready_o
// is high whenever the output slot can move.
module closest_point_on_segment
  import cps_pkg::*;
#(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [COORD_BITS-1:0] foot_x_o,
  output logic signed [COORD_BITS-1:0] foot_y_o,
  output logic [COORD_BITS:0]          distance_o
);
  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = CW + 1;         // differences
  localparam int unsigned PW = 2 * DW;         // one product
  localparam int unsigned LW = PW + 1;         // sum of two products
  localparam int unsigned TW = T_FRAC_BITS;
  localparam int unsigned QS = TW + 1;         // divider stages
  localparam int unsigned VW = 2 * (CW + 2) + 2; // squared distance, even
  localparam int unsigned RN = VW / 2;         // root bits / sqrt stages
  localparam int unsigned UW = DW + TW;        // |d| * t

  logic en;
  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  // Stage 1: differences.
  logic v1_q;
  logic signed [DW-1:0] dx1_q, dy1_q, rx1_q, ry1_q;
  logic signed [CW-1:0] px1_q, py1_q, sx1_q, sy1_q, ex1_q, ey1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q <= DW'(end_x_i) - DW'(start_x_i);
      dy1_q <= DW'(end_y_i) - DW'(start_y_i);
      rx1_q <= DW'(point_x_i) - DW'(start_x_i);
      ry1_q <= DW'(point_y_i) - DW'(start_y_i);
      px1_q <= point_x_i;
      py1_q <= point_y_i;
      sx1_q <= start_x_i;
      sy1_q <= start_y_i;
      ex1_q <= end_x_i;
      ey1_q <= end_y_i;
    end
  end

  // Stage 2: the four products.
  logic v2_q;
  logic signed [PW-1:0] pxx_q, pyy_q, pxr_q, pyr_q;
  logic signed [DW-1:0] dx2_q, dy2_q;
  logic signed [CW-1:0] px2_q, py2_q, sx2_q, sy2_q, ex2_q, ey2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_q <= dx1_q * dx1_q;
      pyy_q <= dy1_q * dy1_q;
      pxr_q <= dx1_q * rx1_q;
      pyr_q <= dy1_q * ry1_q;
      dx2_q <= dx1_q; dy2_q <= dy1_q;
      px2_q <= px1_q; py2_q <= py1_q;
      sx2_q <= sx1_q; sy2_q <= sy1_q;
      ex2_q <= ex1_q; ey2_q <= ey1_q;
    end
  end

  // Stage 3: len2, dot and the case decision.
  logic signed [LW-1:0] len2_c, dot_c;
  assign len2_c = LW'(pxx_q) + LW'(pyy_q);
  assign dot_c  = LW'(pxr_q) + LW'(pyr_q);
  logic v3_q, start3_q, end3_q;
  logic [LW-1:0] len3_q, dot3_q;
  logic signed [DW-1:0] dx3_q, dy3_q;
  logic signed [CW-1:0] px3_q, py3_q, sx3_q, sy3_q, ex3_q, ey3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      start3_q <= (len2_c <= 0) || (dot_c <= 0);
      end3_q   <= dot_c >= len2_c;
      len3_q <= len2_c;
      dot3_q <= dot_c;
      dx3_q <= dx2_q; dy3_q <= dy2_q;
      px3_q <= px2_q; py3_q <= py2_q;
      sx3_q <= sx2_q; sy3_q <= sy2_q;
      ex3_q <= ex2_q; ey3_q <= ey2_q;
    end
  end

  // Divider: restoring; a load stage, then one quotient bit per stage; remainder stays below len2 while dot < len2.
  typedef struct packed {
    logic          v;
    logic          st;
    logic          en;
    logic [LW-1:0] den;
    logic [LW-1:0] rem;
    logic [TW-1:0] q;
    logic signed [DW-1:0] dx, dy;
    logic signed [CW-1:0] px, py, sx, sy, ex, ey;
  } div_t;
  div_t dv_q [QS];
  div_t dv_in [QS];
  for (genvar i = 0; i < QS; i++) begin : g_div
    if (i == 0) begin : g_first
      always_comb begin
        dv_in[i]     = '0;
        dv_in[i].v   = v3_q;
        dv_in[i].st  = start3_q;
        dv_in[i].en  = end3_q;
        dv_in[i].den = len3_q;
        dv_in[i].rem = dot3_q;
        dv_in[i].dx  = dx3_q; dv_in[i].dy = dy3_q;
        dv_in[i].px  = px3_q; dv_in[i].py = py3_q;
        dv_in[i].sx  = sx3_q; dv_in[i].sy = sy3_q;
        dv_in[i].ex  = ex3_q; dv_in[i].ey = ey3_q;
      end
    end else begin : g_next
      logic [LW:0] rs;
      logic        ge;
      assign rs = {dv_q[i-1].rem, 1'b0};
      assign ge = rs >= {1'b0, dv_q[i-1].den};
      always_comb begin
        dv_in[i]     = dv_q[i-1];
        dv_in[i].rem = ge ? LW'(rs - {1'b0, dv_q[i-1].den}) : LW'(rs);
        dv_in[i].q   = {dv_q[i-1].q[TW-2:0], ge};
      end
    end
    // Stage register; only the valid bit is cleared by reset.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i].v <= 1'b0;
      end else if (en) begin
        dv_q[i] <= dv_in[i];
      end
    end
  end
  div_t dl;
  assign dl = dv_q[QS-1];

  // Interpolation stage A: magnitudes times t.
  logic vm_q, stm_q, enm_q, nx_q, ny_q;
  logic [UW-1:0] mx_q, my_q;
  logic signed [CW-1:0] pxm_q, pym_q, sxm_q, sym_q, exm_q, eym_q;
  logic [DW-1:0] adx, ady;
  assign adx = dl.dx[DW-1] ? DW'(-dl.dx) : DW'(dl.dx);
  assign ady = dl.dy[DW-1] ? DW'(-dl.dy) : DW'(dl.dy);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= dl.v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q  <= UW'(adx) * UW'(dl.q);
      my_q  <= UW'(ady) * UW'(dl.q);
      nx_q  <= dl.dx[DW-1];
      ny_q  <= dl.dy[DW-1];
      stm_q <= dl.st; enm_q <= dl.en;
      pxm_q <= dl.px; pym_q <= dl.py;
      sxm_q <= dl.sx; sym_q <= dl.sy;
      exm_q <= dl.ex; eym_q <= dl.ey;
    end
  end

  // Interpolation stage B: foot point and offset from the query.
  logic signed [DW-1:0] stx, sty, ix, iy;
  logic signed [CW-1:0] fxc, fyc;
  assign stx = DW'(mx_q >> TW);
  assign sty = DW'(my_q >> TW);
  assign ix  = nx_q ? DW'(sxm_q) - stx : DW'(sxm_q) + stx;
  assign iy  = ny_q ? DW'(sym_q) - sty : DW'(sym_q) + sty;
  always_comb begin
    if (stm_q) begin
      fxc = sxm_q; fyc = sym_q;
    end else if (enm_q) begin
      fxc = exm_q; fyc = eym_q;
    end else begin
      fxc = CW'(ix); fyc = CW'(iy);
    end
  end
  logic vf_q;
  logic signed [DW-1:0] qx_q, qy_q;
  logic signed [CW-1:0] fx_q, fy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= vm_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q <= DW'(pxm_q) - DW'(fxc);
      qy_q <= DW'(pym_q) - DW'(fyc);
      fx_q <= fxc; fy_q <= fyc;
    end
  end

  // Squared distance.
  logic vs_q;
  logic [VW-1:0] d2_q;
  logic signed [CW-1:0] fxs_q, fys_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (en) begin
      vs_q <= vf_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q  <= VW'(PW'(qx_q * qx_q)) + VW'(PW'(qy_q * qy_q));
      fxs_q <= fx_q; fys_q <= fy_q;
    end
  end

  // Square root: one root bit per stage, most significant first.
  logic              sv [RN+1];
  logic [VW-1:0]     sr [RN+1];
  logic [RN-1:0]     so [RN+1];
  logic signed [CW-1:0] sfx [RN+1];
  logic signed [CW-1:0] sfy [RN+1];
  assign sv[0] = vs_q; assign sr[0] = d2_q; assign so[0] = '0;
  assign sfx[0] = fxs_q; assign sfy[0] = fys_q;
  for (genvar k = 0; k < RN; k++) begin : g_sqrt
    cps_sqrt_stage #(
      .VW(VW), .RW(RN), .BitIdx(RN - 1 - k), .FW(CW), .SW(FracBits)
    ) u_stage (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(sv[k]), .rem_i(sr[k]), .root_i(so[k]), .fx_i(sfx[k]), .fy_i(sfy[k]),
      .valid_o(sv[k+1]), .rem_o(sr[k+1]), .root_o(so[k+1]),
      .fx_o(sfx[k+1]), .fy_o(sfy[k+1])
    );
  end

  assign valid_o    = sv[RN];
  assign foot_x_o   = sfx[RN];
  assign foot_y_o   = sfy[RN];
  assign distance_o = (CW+1)'(so[RN]);
  logic unused_rem;
  assign unused_rem = ^sr[RN];
endmodule
